// ===== rtl/pls_pkg.sv =====
// shared types and constants for the positional list store
// no dependencies; imported by pls_cell and positional_list_store
`default_nettype none

package pls_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LEN_W    = 11;
    localparam int KIND_W   = 3;
    localparam int POS_W    = 8;
    localparam int STAT_W   = 2;
    localparam int DATA_W   = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // operation broadcast to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             rd;
        logic [IDX_W-1:0] pos;
    } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/positional_list_store.sv =====
// top level of the positional list store: request decode, length counter,
// row of pls_cell slots and the result register; depends on pls_pkg, pls_cell
//
//  channel   dir   handshake            payload
//  request   in    s_valid / s_ready    s_kind, s_value, s_position
//  result    out   m_valid / m_ready    m_status, m_read_value, m_length
//
// one request per cycle unless the result stalls: a request is decoded and applied
// to every slot in the cycle it is accepted, the slots shifting in parallel; its
// result appears in the result register in the following cycle.
// reset clears the length and the result valid; slot contents stay undefined.
// a stalled result holds the request side only while the result register is full.
`default_nettype none

module positional_list_store (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [pls_pkg::KIND_W-1:0]    s_kind,
    input  wire  signed [pls_pkg::DATA_W-1:0] s_value,
    input  wire  [pls_pkg::POS_W-1:0]     s_position,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [pls_pkg::STAT_W-1:0]    m_status,
    output logic signed [pls_pkg::DATA_W-1:0] m_read_value,
    output logic [pls_pkg::LEN_W-1:0]     m_length
);
    import pls_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    data_t             m_read_value_reg;
    logic [LEN_W-1:0]  m_length_reg;

    logic              accept;
    ctl_t              ctl;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  pos_ext;
    logic [LEN_W-1:0]  cnt_ext;
    logic [LEN_W-1:0]  ins_pos;
    logic              full;
    logic              empty;

    data_t entries [CAPACITY];
    data_t rd_chain [CAPACITY+1];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign pos_ext = LEN_W'(s_position);
    assign cnt_ext = LEN_W'(count_reg);
    assign full    = (cnt_ext >= LEN_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb begin
        ctl        = '0;
        status     = ST_OK;
        count_next = count_reg;
        ins_pos    = pos_ext;
        case (s_kind)
            KIND_INS_FRONT, KIND_INS_AT, KIND_APPEND: begin
                if (s_kind == KIND_INS_FRONT) begin
                    ins_pos = '0;
                end else if (s_kind == KIND_APPEND) begin
                    ins_pos = cnt_ext;
                end
                if (full) begin
                    status = ST_FULL;
                end else if (ins_pos > cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    ctl.ins    = 1'b1;
                    ctl.pos    = ins_pos[IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_DELETE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    ctl.del    = 1'b1;
                    ctl.pos    = pos_ext[IDX_W-1:0];
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_READ: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    ctl.rd  = 1'b1;
                    ctl.pos = pos_ext[IDX_W-1:0];
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign rd_chain[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        data_t left_entry;
        data_t right_entry;
        if (i == 0) begin : g_first
            assign left_entry = '0;
        end else begin : g_mid_l
            assign left_entry = entries[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_mid_r
            assign right_entry = entries[i+1];
        end
        pls_cell u_cell (
            .aclk        (aclk),
            .accept      (accept),
            .ctl         (ctl),
            .own_idx     (IDX_W'(i)),
            .ins_value   (s_value),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .rd_in       (rd_chain[i]),
            .entry       (entries[i]),
            .rd_out      (rd_chain[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg     <= status;
            m_read_value_reg <= rd_chain[CAPACITY];
            m_length_reg     <= LEN_W'(count_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_read_value = m_read_value_reg;
    assign m_length     = m_length_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        LEN_W'(count_reg) <= LEN_W'(CAPACITY))
        else $error("list length beyond capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ctl.ins) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted insert did not grow the list");

    a_reject_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_read_value == '0))
        else $error("rejected request carries read data");

    a_length_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_valid && m_length == LEN_W'(count_reg)))
        else $error("result length differs from list length");

endmodule

`default_nettype wire

// ===== rtl/pls_cell.sv =====
// one list slot: holds an entry, shifts with its neighbours, joins the read chain
// depends on pls_pkg
`default_nettype none

module pls_cell (
    input  wire                       aclk,
    input  wire                       accept,
    input  wire pls_pkg::ctl_t        ctl,
    input  wire  [pls_pkg::IDX_W-1:0] own_idx,
    input  wire pls_pkg::data_t       ins_value,
    input  wire pls_pkg::data_t       left_entry,
    input  wire pls_pkg::data_t       right_entry,
    input  wire pls_pkg::data_t       rd_in,
    output pls_pkg::data_t            entry,
    output pls_pkg::data_t            rd_out
);
    import pls_pkg::*;

    data_t entry_reg;
    data_t entry_next;
    logic  we;

    always_comb begin
        entry_next = entry_reg;
        we         = 1'b0;
        if (ctl.ins) begin
            if (own_idx > ctl.pos) begin
                entry_next = left_entry;
                we         = 1'b1;
            end else if (own_idx == ctl.pos) begin
                entry_next = ins_value;
                we         = 1'b1;
            end
        end else if (ctl.del && own_idx >= ctl.pos) begin
            entry_next = right_entry;
            we         = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && we) begin
            entry_reg <= entry_next;
        end
    end

    assign entry  = entry_reg;
    // read data ripples along the row, only the addressed slot contributes
    assign rd_out = (ctl.rd && own_idx == ctl.pos) ? (rd_in | entry_reg) : rd_in;

endmodule

`default_nettype wire
